>>> rtl/dcr_pkg.sv
// Package: shared constants, register codes and reset values for the relax unit
`timescale 1ns / 1ps
package dcr_pkg;

    localparam int COORD_INT_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF      = 8;

    localparam int REST_W  = 20;
    localparam int RESTI_W = 9;
    localparam int TOL_W   = 16;
    localparam int EXT_W   = 13;
    localparam int RAD_W   = 16;
    localparam int CFG_DW  = 20;
    localparam int CFG_AW  = 3;

    typedef enum logic [CFG_AW-1:0] {
        REG_REST_LENGTH  = 3'd0,
        REG_RESTITUTION  = 3'd1,
        REG_TOLERANCE    = 3'd2,
        REG_SCREEN_WIDTH = 3'd3,
        REG_SCREEN_HEIGHT = 3'd4
    } t_cfg_reg;

    localparam logic [REST_W-1:0]  RST_REST_LENGTH   = 20'd25600;
    localparam logic [RESTI_W-1:0] RST_RESTITUTION   = 9'd128;
    localparam logic [TOL_W-1:0]   RST_TOLERANCE     = 16'd128;
    localparam logic [EXT_W-1:0]   RST_SCREEN_WIDTH  = 13'd1024;
    localparam logic [EXT_W-1:0]   RST_SCREEN_HEIGHT = 13'd768;

endpackage

>>> rtl/dcr_sqrt.sv
// Pipelined floor square root, one root bit per stage
`timescale 1ns / 1ps
module dcr_sqrt #(
    parameter int LW = 21
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [2*LW-1:0]   i_value,
    output logic [LW-1:0]     o_root
);

    localparam int RW = LW + 3;

    logic [RW-1:0]   r_rem  [LW];
    logic [LW-1:0]   r_root [LW];
    logic [2*LW-1:0] r_val  [LW];

    for (genvar g = 0; g < LW; g++) begin : g_stage
        logic [RW-1:0]   p_rem;
        logic [LW-1:0]   p_root;
        logic [2*LW-1:0] p_val;
        logic [RW-1:0]   n_sh;
        logic [RW-1:0]   n_t;
        logic            n_ge;

        if (g == 0) begin : g_first
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_val  = i_value;
        end else begin : g_next
            assign p_rem  = r_rem[g-1];
            assign p_root = r_root[g-1];
            assign p_val  = r_val[g-1];
        end

        assign n_sh = {p_rem[RW-3:0], p_val[2*(LW-1-g)+1 -: 2]};
        assign n_t  = RW'({p_root, 2'b01});
        assign n_ge = n_sh >= n_t;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= n_ge ? n_sh - n_t : n_sh;
                r_root[g] <= {p_root[LW-2:0], n_ge};
                r_val[g]  <= p_val;
            end
        end
    end

    assign o_root = r_root[LW-1];

endmodule

>>> rtl/dcr_div.sv
// Pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module dcr_div #(
    parameter int NW = 62,
    parameter int DW = 29,
    parameter int QW = 22
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_quo
);

    logic [NW-1:0] r_rem [QW];
    logic [DW-1:0] r_den [QW];
    logic [QW-1:0] r_quo [QW];

    for (genvar g = 0; g < QW; g++) begin : g_stage
        logic [NW-1:0] p_rem;
        logic [DW-1:0] p_den;
        logic [QW-1:0] p_quo;
        logic [NW-1:0] n_sh;
        logic          n_ge;

        if (g == 0) begin : g_first
            assign p_rem = i_num;
            assign p_den = i_den;
            assign p_quo = '0;
        end else begin : g_next
            assign p_rem = r_rem[g-1];
            assign p_den = r_den[g-1];
            assign p_quo = r_quo[g-1];
        end

        assign n_sh = NW'(p_den) << (QW - 1 - g);
        assign n_ge = p_rem >= n_sh;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g] <= n_ge ? p_rem - n_sh : p_rem;
                r_den[g] <= p_den;
                r_quo[g] <= {p_quo[QW-2:0], n_ge};
            end
        end
    end

    assign o_quo = r_quo[QW-1];

endmodule

>>> rtl/distance_constraint_relax_unit.sv
// Top level: distance constraint relaxation pipeline for one spring per request
//
// Input channel: i_valid / o_stall carry one spring request (both end positions
// and radii). Output channel: o_valid / i_stall carry the updated positions and
// the relaxed flag. Configuration: i_cfg_we writes register i_cfg_idx with
// i_cfg_data; unknown indexes are ignored.
// Throughput: one request per cycle, back to back, unless the output stalls.
// Path from accept to o_valid: stages A and B, LW square root stages, stages
// C and D, QW divider stages, stage E; LW is COORD_BITS+1 (one stage per root
// bit), QW is max(LW,20)+1 (one per quotient bit); default coordinates Q12.8.
// The square root and the two dividers set the depth.
// Reset clears the valid bits of every stage and loads the register defaults.
// When the receiver stalls a waiting result, the whole pipeline holds and
// o_stall rises; nothing is dropped or repeated.
`timescale 1ns / 1ps
module distance_constraint_relax_unit #(
    parameter int COORD_INT_BITS = dcr_pkg::COORD_INT_BITS_DEF,
    parameter int FRAC_BITS      = dcr_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [COORD_INT_BITS+FRAC_BITS-1:0] i_first_x,
    input  logic [COORD_INT_BITS+FRAC_BITS-1:0] i_first_y,
    input  logic [COORD_INT_BITS+FRAC_BITS-1:0] i_second_x,
    input  logic [COORD_INT_BITS+FRAC_BITS-1:0] i_second_y,
    input  logic [dcr_pkg::RAD_W-1:0]         i_first_radius,
    input  logic [dcr_pkg::RAD_W-1:0]         i_second_radius,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [COORD_INT_BITS+FRAC_BITS-1:0] o_new_first_x,
    output logic [COORD_INT_BITS+FRAC_BITS-1:0] o_new_first_y,
    output logic [COORD_INT_BITS+FRAC_BITS-1:0] o_new_second_x,
    output logic [COORD_INT_BITS+FRAC_BITS-1:0] o_new_second_y,
    output logic                              o_relaxed,
    input  logic                              i_cfg_we,
    input  logic [dcr_pkg::CFG_AW-1:0]        i_cfg_idx,
    input  logic [dcr_pkg::CFG_DW-1:0]        i_cfg_data
);

    localparam int CB   = COORD_INT_BITS + FRAC_BITS;
    localparam int LW   = CB + 1;
    localparam int AEW  = (LW > dcr_pkg::REST_W) ? LW : dcr_pkg::REST_W;
    localparam int SW   = 2 * LW;
    localparam int PRW  = CB + dcr_pkg::RESTI_W;
    localparam int NW   = PRW + AEW + 1;
    localparam int DW   = LW + 8;
    localparam int QW   = AEW + 1;
    localparam int TW   = CB + 8;
    localparam int XW   = AEW + 16;
    localparam int SBW  = 4 * CB + 2 * dcr_pkg::RAD_W;
    localparam int QSBW = SBW + 2 * CB + 2;
    localparam int DSBW = SBW + 4;
    localparam int SHL  = (FRAC_BITS >= 8) ? FRAC_BITS - 8 : 0;
    localparam int SHR  = (FRAC_BITS >= 8) ? 0 : 8 - FRAC_BITS;
    localparam int LAT  = 2 + LW + 2 + QW + 1;

    localparam logic signed [TW-1:0] ONE  = TW'(64'd1 << FRAC_BITS);
    localparam logic signed [TW-1:0] CMAX = TW'((64'd1 << CB) - 64'd1);

    // configuration
    logic [dcr_pkg::REST_W-1:0]  r_rest_length;
    logic [dcr_pkg::RESTI_W-1:0] r_restitution;
    logic [dcr_pkg::TOL_W-1:0]   r_tolerance;
    logic [dcr_pkg::EXT_W-1:0]   r_screen_width;
    logic [dcr_pkg::EXT_W-1:0]   r_screen_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rest_length   <= dcr_pkg::RST_REST_LENGTH;
            r_restitution   <= dcr_pkg::RST_RESTITUTION;
            r_tolerance     <= dcr_pkg::RST_TOLERANCE;
            r_screen_width  <= dcr_pkg::RST_SCREEN_WIDTH;
            r_screen_height <= dcr_pkg::RST_SCREEN_HEIGHT;
        end else if (i_cfg_we) begin
            unique case (dcr_pkg::t_cfg_reg'(i_cfg_idx))
                dcr_pkg::REG_REST_LENGTH: begin
                    r_rest_length <= i_cfg_data[dcr_pkg::REST_W-1:0];
                end
                dcr_pkg::REG_RESTITUTION: begin
                    r_restitution <= i_cfg_data[dcr_pkg::RESTI_W-1:0];
                end
                dcr_pkg::REG_TOLERANCE: begin
                    r_tolerance <= i_cfg_data[dcr_pkg::TOL_W-1:0];
                end
                dcr_pkg::REG_SCREEN_WIDTH: begin
                    r_screen_width <= i_cfg_data[dcr_pkg::EXT_W-1:0];
                end
                dcr_pkg::REG_SCREEN_HEIGHT: begin
                    r_screen_height <= i_cfg_data[dcr_pkg::EXT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // flow control
    logic           en;
    logic [LAT-1:0] r_vld;

    assign en      = !r_vld[LAT-1] || !i_stall;
    assign o_stall = r_vld[LAT-1] && i_stall;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // stage A: absolute differences
    logic [SBW-1:0] r_a_sb;
    logic [CB-1:0]  r_a_adx, r_a_ady;
    logic           r_a_nx, r_a_ny;
    logic           n_a_nx, n_a_ny;

    assign n_a_nx = i_second_x > i_first_x;
    assign n_a_ny = i_second_y > i_first_y;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_sb  <= {i_first_x, i_first_y, i_second_x, i_second_y,
                        i_first_radius, i_second_radius};
            r_a_adx <= n_a_nx ? i_second_x - i_first_x : i_first_x - i_second_x;
            r_a_ady <= n_a_ny ? i_second_y - i_first_y : i_first_y - i_second_y;
            r_a_nx  <= n_a_nx;
            r_a_ny  <= n_a_ny;
        end
    end

    // stage B: squared length
    logic [2*CB-1:0] n_b_sqx, n_b_sqy;
    logic [SW-1:0]   r_b_sum;
    logic [QSBW-1:0] r_b_sb;

    assign n_b_sqx = r_a_adx * r_a_adx;
    assign n_b_sqy = r_a_ady * r_a_ady;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_sum <= SW'(n_b_sqx) + SW'(n_b_sqy);
            r_b_sb  <= {r_a_sb, r_a_adx, r_a_ady, r_a_nx, r_a_ny};
        end
    end

    // square root stages, request data travels alongside
    logic [LW-1:0]   q_len;
    logic [QSBW-1:0] r_q_sb [LW];

    dcr_sqrt #(.LW(LW)) u_sqrt (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_value (r_b_sum),
        .o_root  (q_len)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_q_sb[0] <= r_b_sb;
            for (int k = 1; k < LW; k++) begin
                r_q_sb[k] <= r_q_sb[k-1];
            end
        end
    end

    // stage C: length error, dead band, first products
    logic [SBW-1:0] c_side;
    logic [CB-1:0]  c_adx, c_ady;
    logic           c_nx, c_ny;
    logic [AEW-1:0] c_len, c_rest, c_ae;
    logic           c_eneg, c_pass;
    logic [XW-1:0]  c_tol;

    assign {c_side, c_adx, c_ady, c_nx, c_ny} = r_q_sb[LW-1];
    assign c_len  = AEW'(q_len);
    assign c_rest = AEW'(r_rest_length);
    assign c_eneg = c_len < c_rest;
    assign c_ae   = c_eneg ? c_rest - c_len : c_len - c_rest;
    assign c_tol  = (XW'(r_tolerance) << SHL) >> SHR;
    assign c_pass = (q_len == '0) || (XW'(c_ae) <= c_tol);

    logic [LW-1:0]   r_c_len;
    logic [AEW-1:0]  r_c_ae;
    logic [PRW-1:0]  r_c_px, r_c_py;
    logic [DSBW-1:0] r_c_sb;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_len <= q_len;
            r_c_ae  <= c_ae;
            r_c_px  <= c_adx * r_restitution;
            r_c_py  <= c_ady * r_restitution;
            r_c_sb  <= {c_side, c_nx, c_ny, c_eneg, c_pass};
        end
    end

    // stage D: numerators with rounding, denominator
    logic [PRW+AEW-1:0] n_d_mx, n_d_my;
    logic [NW-1:0]      r_d_numx, r_d_numy;
    logic [DW-1:0]      r_d_den;
    logic [DSBW-1:0]    r_d_sb;

    assign n_d_mx = r_c_px * r_c_ae;
    assign n_d_my = r_c_py * r_c_ae;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_numx <= NW'(n_d_mx) + NW'({r_c_len, 7'd0});
            r_d_numy <= NW'(n_d_my) + NW'({r_c_len, 7'd0});
            r_d_den  <= {r_c_len, 8'd0};
            r_d_sb   <= r_c_sb;
        end
    end

    // divider stages
    logic [QW-1:0]   v_mx, v_my;
    logic [DSBW-1:0] r_v_sb [QW];

    dcr_div #(.NW(NW), .DW(DW), .QW(QW)) u_div_x (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_d_numx),
        .i_den (r_d_den),
        .o_quo (v_mx)
    );

    dcr_div #(.NW(NW), .DW(DW), .QW(QW)) u_div_y (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_d_numy),
        .i_den (r_d_den),
        .o_quo (v_my)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_v_sb[0] <= r_d_sb;
            for (int k = 1; k < QW; k++) begin
                r_v_sb[k] <= r_v_sb[k-1];
            end
        end
    end

    // stage E: apply moves and clamp into the screen, or pass the positions through
    function automatic logic [CB-1:0] clamp_ax(
        input logic signed [TW-1:0] p,
        input logic signed [TW-1:0] r,
        input logic signed [TW-1:0] hi
    );
        logic signed [TW-1:0] t;
        logic [CB-1:0]        res;
        t = (p < hi) ? p : hi;
        t = (t > r) ? t : r;
        if (t < 0) begin
            res = '0;
        end else if (t > CMAX) begin
            res = CMAX[CB-1:0];
        end else begin
            res = t[CB-1:0];
        end
        return res;
    endfunction

    logic [CB-1:0]            e_x0, e_y0, e_x1, e_y1;
    logic [dcr_pkg::RAD_W-1:0] e_r0, e_r1;
    logic                     e_nx, e_ny, e_eneg, e_pass;
    logic signed [TW-1:0]     e_smx, e_smy, e_rc0, e_rc1;
    logic signed [TW-1:0]     e_hx0, e_hy0, e_hx1, e_hy1;
    logic signed [TW-1:0]     e_wx, e_wy;

    assign {e_x0, e_y0, e_x1, e_y1, e_r0, e_r1, e_nx, e_ny, e_eneg, e_pass} =
        r_v_sb[QW-1];

    assign e_smx = (e_nx ^ e_eneg) ? -TW'(v_mx) : TW'(v_mx);
    assign e_smy = (e_ny ^ e_eneg) ? -TW'(v_my) : TW'(v_my);
    assign e_rc0 = (TW'(e_r0) << SHL) >> SHR;
    assign e_rc1 = (TW'(e_r1) << SHL) >> SHR;
    assign e_wx  = TW'(r_screen_width) << FRAC_BITS;
    assign e_wy  = TW'(r_screen_height) << FRAC_BITS;
    assign e_hx0 = e_wx - e_rc0 - ONE;
    assign e_hy0 = e_wy - e_rc0 - ONE;
    assign e_hx1 = e_wx - e_rc1 - ONE;
    assign e_hy1 = e_wy - e_rc1 - ONE;

    logic [CB-1:0] r_o_x0, r_o_y0, r_o_x1, r_o_y1;
    logic          r_o_relaxed;

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (e_pass) begin
                r_o_x0 <= e_x0;
                r_o_y0 <= e_y0;
                r_o_x1 <= e_x1;
                r_o_y1 <= e_y1;
            end else begin
                r_o_x0 <= clamp_ax(TW'(e_x0) - e_smx, e_rc0, e_hx0);
                r_o_y0 <= clamp_ax(TW'(e_y0) - e_smy, e_rc0, e_hy0);
                r_o_x1 <= clamp_ax(TW'(e_x1) + e_smx, e_rc1, e_hx1);
                r_o_y1 <= clamp_ax(TW'(e_y1) + e_smy, e_rc1, e_hy1);
            end
            r_o_relaxed <= !e_pass;
        end
    end

    assign o_new_first_x  = r_o_x0;
    assign o_new_first_y  = r_o_y0;
    assign o_new_second_x = r_o_x1;
    assign o_new_second_y = r_o_y1;
    assign o_relaxed      = r_o_relaxed;

    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no result waiting");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld))
        else $error("pipeline moved while output stalled");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule
